/* src/ppu_pkg.sv */
// Shared types and constants for the packed pixel point operation unit.
package ppu_pkg;

  localparam int unsigned PIX_W      = 16;
  localparam int unsigned THR_W      = 15;
  localparam int unsigned MODE_W     = 4;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [MODE_W-1:0] {
    OP_ABS     = 4'd0,
    OP_ZTHRESH = 4'd1,
    OP_HARD    = 4'd2,
    OP_SOFT    = 4'd3,
    OP_ISPOS   = 4'd4,
    OP_SIGN    = 4'd5,
    OP_NOT     = 4'd6,
    OP_MASK    = 4'd7,
    OP_AND     = 4'd8,
    OP_OR      = 4'd9,
    OP_XOR     = 4'd10,
    OP_FILL    = 4'd11
  } op_mode_e;

  typedef enum logic [1:0] {
    REG_OP_MODE    = 2'd0,
    REG_THRESHOLD  = 2'd1,
    REG_MASK_VALUE = 2'd2,
    REG_FILL_VALUE = 2'd3
  } reg_idx_e;

  localparam logic [PIX_W-1:0] MASK_RESET = 16'hFFFF;
  localparam logic [PIX_W-1:0] SIGN_MAG   = 16'h7FFF;

  typedef struct packed {
    logic [MODE_W-1:0] op_mode;
    logic [THR_W-1:0]  threshold;
    logic [PIX_W-1:0]  mask_value;
    logic [PIX_W-1:0]  fill_value;
  } ppu_cfg_t;

endpackage

/* src/ppu_cfg_regs.sv */
// Configuration register file behind the APB-style port.
module ppu_cfg_regs
  import ppu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output ppu_cfg_t              cfg_o
);

  ppu_cfg_t cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_OP_MODE:    cfg_d.op_mode    = pwdata[MODE_W-1:0];
        REG_THRESHOLD:  cfg_d.threshold  = pwdata[THR_W-1:0];
        REG_MASK_VALUE: cfg_d.mask_value = pwdata[PIX_W-1:0];
        REG_FILL_VALUE: cfg_d.fill_value = pwdata[PIX_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OP_MODE:    prdata = {{(APB_DATA_W-MODE_W){1'b0}}, cfg_q.op_mode};
      REG_THRESHOLD:  prdata = {{(APB_DATA_W-THR_W){1'b0}}, cfg_q.threshold};
      REG_MASK_VALUE: prdata = {{(APB_DATA_W-PIX_W){1'b0}}, cfg_q.mask_value};
      REG_FILL_VALUE: prdata = {{(APB_DATA_W-PIX_W){1'b0}}, cfg_q.fill_value};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.op_mode    <= OP_ABS;
      cfg_q.threshold  <= '0;
      cfg_q.mask_value <= MASK_RESET;
      cfg_q.fill_value <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/ppu_lane_op.sv */
// Point operation on one 16-bit pixel lane.
module ppu_lane_op
  import ppu_pkg::*;
(
  input  ppu_cfg_t         cfg_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic [PIX_W-1:0] other_i,
  output logic [PIX_W-1:0] result_o
);

  logic [PIX_W-1:0] s;
  logic [THR_W-1:0] a;
  logic [THR_W-1:0] a_minus_t;
  logic             a_ge_t;

  assign s         = {PIX_W{pixel_i[PIX_W-1]}};
  assign a         = pixel_i[THR_W-1:0] ^ s[THR_W-1:0];
  assign a_ge_t    = (a >= cfg_i.threshold);
  assign a_minus_t = a - cfg_i.threshold;

  always_comb begin
    case (op_mode_e'(cfg_i.op_mode))
      OP_ABS:     result_o = pixel_i ^ s;
      OP_ZTHRESH: result_o = pixel_i & ~s;
      OP_HARD:    result_o = a_ge_t ? pixel_i : s;
      OP_SOFT:    result_o = a_ge_t ? ({1'b0, a_minus_t} ^ s) : s;
      OP_ISPOS:   result_o = ~s;
      OP_SIGN:    result_o = s ^ SIGN_MAG;
      OP_NOT:     result_o = ~pixel_i;
      OP_MASK:    result_o = pixel_i & cfg_i.mask_value;
      OP_AND:     result_o = pixel_i & other_i;
      OP_OR:      result_o = pixel_i | other_i;
      OP_XOR:     result_o = pixel_i ^ other_i;
      OP_FILL:    result_o = cfg_i.fill_value;
      default:    result_o = pixel_i;
    endcase
  end

endmodule

/* src/packed_pixel_point_op_unit.sv */
// Top level: input register, per-lane point operations and result register.
// An accepted input word passes the input register, then the result register.
// Throughput: one word per cycle unless stalled; input and result registers
// each hold a word, so one more word is taken while a result waits to be taken.
// Reset clears both valid flags and loads the configuration reset values.
module packed_pixel_point_op_unit
  import ppu_pkg::*;
#(
  parameter int unsigned LANES = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // APB-style configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0]     pwdata,
  output logic [APB_DATA_W-1:0]     prdata,
  output logic                      pready,
  // Input stream: pixel lanes 0 upwards, then other lanes 0 upwards
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [2*LANES*PIX_W-1:0]  s_axis_tdata,
  input  logic                      s_axis_tlast,   // end_of_plane
  // Output stream: result lanes 0 upwards
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [LANES*PIX_W-1:0]    m_axis_tdata,
  output logic                      m_axis_tlast    // end_of_plane_out
);

  ppu_cfg_t cfg;

  logic                     in_valid_q, in_valid_d;
  logic [2*LANES*PIX_W-1:0] in_data_q;
  logic                     in_last_q;
  logic                     out_valid_q, out_valid_d;
  logic [LANES*PIX_W-1:0]   out_data_q, out_data_d;
  logic                     out_last_q;
  logic                     out_ready;
  logic                     in_ready;

  ppu_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ppu_lane_op u_lane (
      .cfg_i    (cfg),
      .pixel_i  (in_data_q[i*PIX_W +: PIX_W]),
      .other_i  (in_data_q[(LANES+i)*PIX_W +: PIX_W]),
      .result_o (out_data_d[i*PIX_W +: PIX_W])
    );
  end

  assign out_ready     = ~out_valid_q | m_axis_tready;
  assign in_ready      = ~in_valid_q | out_ready;
  assign s_axis_tready = in_ready;

  assign in_valid_d  = (s_axis_tvalid & in_ready) | (in_valid_q & ~out_ready);
  assign out_valid_d = (in_valid_q & out_ready) | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && in_ready) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (in_valid_q && out_ready) begin
      out_data_q <= out_data_d;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
